// File: design/ssd_pkg.sv
// ssd_pkg: shared widths, constants and codes for the segment distance pipeline.
// No dependencies.
package ssd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIST_W = 33;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // which value the second divider produces
  typedef enum logic {
    SEL_T = 1'b0,
    SEL_S = 1'b1
  } sel_t;

  function automatic int diff_w(int w);
    return w + 1;
  endfunction

  function automatic int par_w(int w);
    return w + 2;
  endfunction

  function automatic int dot_w(int w);
    return 2 * w + 4;
  endfunction

  function automatic int big_w(int w);
    return 4 * w + 9;
  endfunction

  function automatic int tn_w(int w);
    return 3 * w + 8;
  endfunction

  function automatic int dk_w(int w);
    return 2 * w + 6;
  endfunction

  function automatic int sq_w(int w);
    return 4 * w + 12;
  endfunction

  function automatic int sum_w(int w);
    return 2 * w + 8;
  endfunction

  function automatic int root_w(int w);
    return w + 4;
  endfunction

endpackage

// File: design/ssd_wmul.sv
// ssd_wmul: two-stage signed multiplier built from four half-width partial
// products. Depends on nothing; enable freezes both stages.
module ssd_wmul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int HA  = AW / 2;
  localparam int HAW = AW - HA;
  localparam int HB  = BW / 2;
  localparam int HBW = BW - HB;
  localparam int PW  = AW + BW;

  logic signed [HA+HB+1:0]    pll;
  logic signed [HA+HBW:0]     plh;
  logic signed [HAW+HB:0]     phl;
  logic signed [HAW+HBW-1:0]  phh;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= $signed({1'b0, a[HA-1:0]}) * $signed({1'b0, b[HB-1:0]});
      plh <= $signed({1'b0, a[HA-1:0]}) * $signed(b[BW-1:HB]);
      phl <= $signed(a[AW-1:HA]) * $signed({1'b0, b[HB-1:0]});
      phh <= $signed(a[AW-1:HA]) * $signed(b[BW-1:HB]);
      p   <= (PW'(phh) <<< (HA + HB)) + (PW'(plh) <<< HA) +
             (PW'(phl) <<< HB) + PW'(pll);
    end
  end

endmodule

// File: design/ssd_div.sv
// ssd_div: pipelined restoring divider, one quotient bit per stage, result
// clamped to [0,1] as a QB-bit fraction. Depends on nothing.
module ssd_div #(
  parameter int  NW = 64,
  parameter int  QB = 34,
  parameter type side_t = logic
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 v_in,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  input  side_t                side_in,
  output logic                 v_out,
  output logic [QB:0]          q,
  output side_t                side_out
);

  logic [QB+1:0]   vs;
  logic [NW-1:0]   rem_s [QB+1];
  logic [NW-1:0]   den_s [QB+1];
  logic [QB-1:0]   q_s   [QB+1];
  logic            zero_s [QB+1];
  logic            one_s  [QB+1];
  side_t           side_s [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[QB:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= num;
      den_s[0]  <= den;
      q_s[0]    <= '0;
      zero_s[0] <= (den <= 0) || (num <= 0);
      one_s[0]  <= (den > 0) && (num > 0) && (num >= den);
      side_s[0] <= side_in;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [NW-1:0] sh;
    logic [NW:0]   df;
    assign sh = {rem_s[i-1][NW-2:0], 1'b0};
    assign df = {1'b0, sh} - {1'b0, den_s[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i]  <= df[NW] ? sh : df[NW-1:0];
        den_s[i]  <= den_s[i-1];
        q_s[i]    <= {q_s[i-1][QB-2:0], ~df[NW]};
        zero_s[i] <= zero_s[i-1];
        one_s[i]  <= one_s[i-1];
        side_s[i] <= side_s[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_s[QB]) begin
        q <= '0;
      end else if (one_s[QB]) begin
        q <= {1'b1, {QB{1'b0}}};
      end else begin
        q <= {1'b0, q_s[QB]};
      end
      side_out <= side_s[QB];
    end
  end

  assign v_out = vs[QB+1];

endmodule

// File: design/ssd_sqrt.sv
// ssd_sqrt: pipelined integer square root, two radicand bits per stage,
// floor result. Depends on nothing.
module ssd_sqrt #(
  parameter int XW = 72
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  logic [XW-1:0]     x,
  output logic              v_out,
  output logic [XW/2-1:0]   root
);

  localparam int RB = XW / 2;

  logic [RB-1:0] vs;
  logic [XW-1:0] xs   [RB];
  logic [RB+1:0] rems [RB];
  logic [RB-1:0] rts  [RB];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[RB-2:0], v_in};
    end
  end

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [XW-1:0] x_in;
    logic [RB+1:0] rem_in;
    logic [RB-1:0] rt_in;
    logic [RB+2:0] cur;
    logic [RB+2:0] trial;
    logic [RB+2:0] df;
    if (i == 0) begin : g_first
      assign x_in   = x;
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_next
      assign x_in   = xs[i-1];
      assign rem_in = rems[i-1];
      assign rt_in  = rts[i-1];
    end
    assign cur   = {rem_in[RB:0], x_in[XW-1:XW-2]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign df    = cur - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        xs[i] <= {x_in[XW-3:0], 2'b00};
        if (cur >= trial) begin
          rems[i] <= df[RB+1:0];
          rts[i]  <= {rt_in[RB-2:0], 1'b1};
        end else begin
          rems[i] <= cur[RB+1:0];
          rts[i]  <= {rt_in[RB-2:0], 1'b0};
        end
      end
    end
  end

  assign root  = rts[RB-1];
  assign v_out = vs[RB-1];

endmodule

// File: design/ssd_front.sv
// ssd_front: direction vectors, dot products, denominator and s numerator.
// Depends on ssd_pkg and ssd_wmul. Six register stages.
module ssd_front import ssd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          v_in,
  input  logic signed [W-1:0]           p1 [3],
  input  logic signed [W-1:0]           q1 [3],
  input  logic signed [W-1:0]           p2 [3],
  input  logic signed [W-1:0]           q2 [3],
  output logic                          v_out,
  output logic [2:0][diff_w(W)-1:0]     d1,
  output logic [2:0][diff_w(W)-1:0]     d2,
  output logic [2:0][diff_w(W)-1:0]     r,
  output logic signed [dot_w(W)-1:0]    a,
  output logic signed [dot_w(W)-1:0]    b,
  output logic signed [dot_w(W)-1:0]    c,
  output logic signed [dot_w(W)-1:0]    e,
  output logic signed [dot_w(W)-1:0]    f,
  output logic signed [big_w(W)-1:0]    denom,
  output logic signed [big_w(W)-1:0]    snum
);

  localparam int DW   = diff_w(W);
  localparam int DOTW = dot_w(W);
  localparam int BGW  = big_w(W);

  logic [5:0] vs;
  logic signed [DW-1:0]     d1s [6][3];
  logic signed [DW-1:0]     d2s [6][3];
  logic signed [DW-1:0]     rs  [6][3];
  logic signed [2*DW-1:0]   paa [3];
  logic signed [2*DW-1:0]   pee [3];
  logic signed [2*DW-1:0]   pbb [3];
  logic signed [2*DW-1:0]   pcc [3];
  logic signed [2*DW-1:0]   pff [3];
  logic signed [DOTW-1:0]   as_s [2:5];
  logic signed [DOTW-1:0]   bs_s [2:5];
  logic signed [DOTW-1:0]   cs_s [2:5];
  logic signed [DOTW-1:0]   es_s [2:5];
  logic signed [DOTW-1:0]   fs_s [2:5];
  logic signed [2*DOTW-1:0] ae;
  logic signed [2*DOTW-1:0] bb;
  logic signed [2*DOTW-1:0] bf;
  logic signed [2*DOTW-1:0] ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[4:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1s[0][k] <= DW'(q1[k]) - DW'(p1[k]);
        d2s[0][k] <= DW'(q2[k]) - DW'(p2[k]);
        rs[0][k]  <= DW'(p1[k]) - DW'(p2[k]);
        for (int st = 1; st < 6; st++) begin
          d1s[st][k] <= d1s[st-1][k];
          d2s[st][k] <= d2s[st-1][k];
          rs[st][k]  <= rs[st-1][k];
        end
        paa[k] <= d1s[0][k] * d1s[0][k];
        pee[k] <= d2s[0][k] * d2s[0][k];
        pbb[k] <= d1s[0][k] * d2s[0][k];
        pcc[k] <= d1s[0][k] * rs[0][k];
        pff[k] <= d2s[0][k] * rs[0][k];
      end
      as_s[2] <= DOTW'(paa[0]) + DOTW'(paa[1]) + DOTW'(paa[2]);
      es_s[2] <= DOTW'(pee[0]) + DOTW'(pee[1]) + DOTW'(pee[2]);
      bs_s[2] <= DOTW'(pbb[0]) + DOTW'(pbb[1]) + DOTW'(pbb[2]);
      cs_s[2] <= DOTW'(pcc[0]) + DOTW'(pcc[1]) + DOTW'(pcc[2]);
      fs_s[2] <= DOTW'(pff[0]) + DOTW'(pff[1]) + DOTW'(pff[2]);
      for (int st = 3; st < 6; st++) begin
        as_s[st] <= as_s[st-1];
        bs_s[st] <= bs_s[st-1];
        cs_s[st] <= cs_s[st-1];
        es_s[st] <= es_s[st-1];
        fs_s[st] <= fs_s[st-1];
      end
      denom <= BGW'(ae) - BGW'(bb);
      snum  <= BGW'(bf) - BGW'(ce);
    end
  end

  ssd_wmul #(.AW(DOTW), .BW(DOTW)) u_ae (
    .clk(clk), .en(en), .a(as_s[2]), .b(es_s[2]), .p(ae)
  );
  ssd_wmul #(.AW(DOTW), .BW(DOTW)) u_bb (
    .clk(clk), .en(en), .a(bs_s[2]), .b(bs_s[2]), .p(bb)
  );
  ssd_wmul #(.AW(DOTW), .BW(DOTW)) u_bf (
    .clk(clk), .en(en), .a(bs_s[2]), .b(fs_s[2]), .p(bf)
  );
  ssd_wmul #(.AW(DOTW), .BW(DOTW)) u_ce (
    .clk(clk), .en(en), .a(cs_s[2]), .b(es_s[2]), .p(ce)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1[k] = d1s[5][k];
      d2[k] = d2s[5][k];
      r[k]  = rs[5][k];
    end
  end

  assign a     = as_s[5];
  assign b     = bs_s[5];
  assign c     = cs_s[5];
  assign e     = es_s[5];
  assign f     = fs_s[5];
  assign v_out = vs[5];

endmodule

// File: design/ssd_mid.sv
// ssd_mid: t numerator from s, range test on t, operands for the second divide.
// Depends on ssd_pkg. Three register stages.
module ssd_mid import ssd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          v_in,
  input  logic [par_w(W):0]             s,
  input  logic signed [dot_w(W)-1:0]    a,
  input  logic signed [dot_w(W)-1:0]    b,
  input  logic signed [dot_w(W)-1:0]    c,
  input  logic signed [dot_w(W)-1:0]    e,
  input  logic signed [dot_w(W)-1:0]    f,
  input  logic [2:0][diff_w(W)-1:0]     d1_in,
  input  logic [2:0][diff_w(W)-1:0]     d2_in,
  input  logic [2:0][diff_w(W)-1:0]     r_in,
  output logic                          v_out,
  output logic signed [tn_w(W)-1:0]     dnum,
  output logic signed [tn_w(W)-1:0]     dden,
  output sel_t                          mode,
  output logic [par_w(W):0]             s_old,
  output logic [par_w(W):0]             t_fix,
  output logic [2:0][diff_w(W)-1:0]     d1,
  output logic [2:0][diff_w(W)-1:0]     d2,
  output logic [2:0][diff_w(W)-1:0]     r
);

  localparam int PW  = par_w(W);
  localparam int TW  = tn_w(W);
  localparam int DW  = diff_w(W);
  localparam int DTW = dot_w(W);
  localparam int HB  = DTW / 2;

  logic [2:0] vs;
  logic [2:0][DW-1:0] d1s [3];
  logic [2:0][DW-1:0] d2s [3];
  logic [2:0][DW-1:0] rs  [3];
  logic [PW:0]        ss  [2];
  logic signed [HB+PW+2:0]     bsl;
  logic signed [DTW-HB+PW+1:0] bsh;
  logic signed [TW-1:0] fp;
  logic signed [TW-1:0] tnum;
  logic signed [TW-1:0] ep;
  logic signed [TW-1:0] negc;
  logic signed [TW-1:0] bmc;
  logic signed [TW-1:0] aw;
  logic signed [dot_w(W)-1:0] a1;
  logic signed [dot_w(W)-1:0] b1;
  logic signed [dot_w(W)-1:0] c1;
  logic signed [dot_w(W)-1:0] e1;
  logic ez;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1s[0] <= d1_in;
      d2s[0] <= d2_in;
      rs[0]  <= r_in;
      for (int st = 1; st < 3; st++) begin
        d1s[st] <= d1s[st-1];
        d2s[st] <= d2s[st-1];
        rs[st]  <= rs[st-1];
      end
      ss[0] <= s;
      ss[1] <= ss[0];
      s_old <= ss[1];

      bsl <= $signed({1'b0, b[HB-1:0]}) * $signed({1'b0, s});
      bsh <= $signed(b[DTW-1:HB]) * $signed({1'b0, s});
      fp <= TW'(f) <<< PW;
      a1 <= a;
      b1 <= b;
      c1 <= c;
      e1 <= e;

      tnum <= (TW'(bsh) <<< HB) + TW'(bsl) + fp;
      ep   <= TW'(e1) <<< PW;
      ez   <= (e1 == '0);
      negc <= -TW'(c1);
      bmc  <= TW'(b1) - TW'(c1);
      aw   <= TW'(a1);

      if (ez || (tnum < 0)) begin
        mode  <= SEL_S;
        dnum  <= negc;
        dden  <= aw;
        t_fix <= '0;
      end else if (tnum > ep) begin
        mode  <= SEL_S;
        dnum  <= bmc;
        dden  <= aw;
        t_fix <= {1'b1, {PW{1'b0}}};
      end else begin
        mode  <= SEL_T;
        dnum  <= tnum;
        dden  <= ep;
        t_fix <= '0;
      end
    end
  end

  assign d1    = d1s[2];
  assign d2    = d2s[2];
  assign r     = rs[2];
  assign v_out = vs[2];

endmodule

// File: design/ssd_back.sv
// ssd_back: closest-point difference vector, its squared length, scaled down.
// Depends on ssd_pkg and ssd_wmul. Five register stages.
module ssd_back import ssd_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      v_in,
  input  logic [par_w(W):0]         s,
  input  logic [par_w(W):0]         t,
  input  logic [2:0][diff_w(W)-1:0] d1,
  input  logic [2:0][diff_w(W)-1:0] d2,
  input  logic [2:0][diff_w(W)-1:0] r,
  output logic                      v_out,
  output logic [sum_w(W)-1:0]       sq
);

  localparam int PW  = par_w(W);
  localparam int DKW = dk_w(W);
  localparam int SQW = sq_w(W);

  logic [4:0] vs;
  logic signed [DKW-1:0]   ps [3];
  logic signed [DKW-1:0]   pt [3];
  logic signed [DKW-1:0]   rp [3];
  logic signed [DKW-1:0]   dk [3];
  logic signed [2*DKW-1:0] sqk [3];
  logic [SQW-1:0]          sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[3:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ps[k] <= $signed(d1[k]) * $signed({1'b0, s});
        pt[k] <= $signed(d2[k]) * $signed({1'b0, t});
        rp[k] <= DKW'($signed(r[k])) <<< PW;
        dk[k] <= rp[k] + ps[k] - pt[k];
      end
      sum <= $unsigned(sqk[0]) + $unsigned(sqk[1]) + $unsigned(sqk[2]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sq
    ssd_wmul #(.AW(DKW), .BW(DKW)) u_sq (
      .clk(clk), .en(en), .a(dk[k]), .b(dk[k]), .p(sqk[k])
    );
  end

  assign sq    = sum[SQW-1:2*PW];
  assign v_out = vs[4];

endmodule

// File: design/segment_segment_distance_top.sv
// segment_segment_distance_top: shortest distance between two 3D segments.
// Depends on ssd_pkg, ssd_front, ssd_div, ssd_mid, ssd_back, ssd_sqrt.
//
// Usage:
//   Input channel (seg_valid / seg_stall) carries the four endpoints of two
//   segments, signed fixed point of COORD_WIDTH bits. A transaction moves on
//   a rising edge with seg_valid high and seg_stall low.
//   Output channel (dist_valid / dist_stall) returns one distance per input
//   transaction, in order, unsigned, same fraction bits as the inputs,
//   saturated at 2^33-1.
//   The pipeline is the front end, two 36-stage dividers around the mid
//   stages, the squared-length stages and the 36-stage square root, at the
//   default width. Throughput is one transaction per cycle unless stalled.
//   All stages advance together; a held result with dist_stall high freezes
//   the whole pipeline and raises seg_stall in the same cycle, so nothing is
//   lost or repeated.
//   Reset clears every valid bit; no result appears until a new transaction.
module segment_segment_distance_top import ssd_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         seg_valid,
  output logic                         seg_stall,
  input  logic signed [COORD_WIDTH-1:0] seg1_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg1_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg1_start_z,
  input  logic signed [COORD_WIDTH-1:0] seg1_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg1_end_y,
  input  logic signed [COORD_WIDTH-1:0] seg1_end_z,
  input  logic signed [COORD_WIDTH-1:0] seg2_start_x,
  input  logic signed [COORD_WIDTH-1:0] seg2_start_y,
  input  logic signed [COORD_WIDTH-1:0] seg2_start_z,
  input  logic signed [COORD_WIDTH-1:0] seg2_end_x,
  input  logic signed [COORD_WIDTH-1:0] seg2_end_y,
  input  logic signed [COORD_WIDTH-1:0] seg2_end_z,
  output logic                         dist_valid,
  input  logic                         dist_stall,
  output logic [DIST_W-1:0]            distance
);

  localparam int W    = COORD_WIDTH;
  localparam int DW   = diff_w(W);
  localparam int PW   = par_w(W);
  localparam int DOTW = dot_w(W);
  localparam int BGW  = big_w(W);
  localparam int TW   = tn_w(W);
  localparam int SW   = sum_w(W);
  localparam int RW   = root_w(W);
  localparam int XW   = (RW > DIST_W) ? RW : DIST_W;

  typedef struct packed {
    logic [2:0][DW-1:0] d1;
    logic [2:0][DW-1:0] d2;
    logic [2:0][DW-1:0] r;
    logic [DOTW-1:0]    a;
    logic [DOTW-1:0]    b;
    logic [DOTW-1:0]    c;
    logic [DOTW-1:0]    e;
    logic [DOTW-1:0]    f;
  } side1_t;

  typedef struct packed {
    logic [2:0][DW-1:0] d1;
    logic [2:0][DW-1:0] d2;
    logic [2:0][DW-1:0] r;
    logic [PW:0]        s_old;
    logic [PW:0]        t_fix;
    sel_t               mode;
  } side2_t;

  logic en;
  logic signed [W-1:0] p1 [3];
  logic signed [W-1:0] q1 [3];
  logic signed [W-1:0] p2 [3];
  logic signed [W-1:0] q2 [3];

  logic                   f_v;
  logic [2:0][DW-1:0]     f_d1, f_d2, f_r;
  logic signed [DOTW-1:0] f_a, f_b, f_c, f_e, f_f;
  logic signed [BGW-1:0]  f_den, f_num;
  side1_t                 side1_in, side1_out;

  logic                   q1_v;
  logic [PW:0]            s_q;

  logic                   m_v;
  logic signed [TW-1:0]   m_num, m_den;
  sel_t                   m_mode;
  logic [PW:0]            m_s, m_t;
  logic [2:0][DW-1:0]     m_d1, m_d2, m_r;
  side2_t                 side2_in, side2_out;

  logic                   q2_v;
  logic [PW:0]            q2_val;
  logic [PW:0]            s_fin, t_fin;

  logic                   b_v;
  logic [SW-1:0]          b_sq;
  logic                   r_v;
  logic [RW-1:0]          root;
  logic [XW-1:0]          root_x;

  assign en        = !(dist_valid && dist_stall);
  assign seg_stall = !en;

  assign p1 = '{seg1_start_x, seg1_start_y, seg1_start_z};
  assign q1 = '{seg1_end_x, seg1_end_y, seg1_end_z};
  assign p2 = '{seg2_start_x, seg2_start_y, seg2_start_z};
  assign q2 = '{seg2_end_x, seg2_end_y, seg2_end_z};

  ssd_front #(.W(W)) u_front (
    .clk(clk), .rst(rst), .en(en), .v_in(seg_valid),
    .p1(p1), .q1(q1), .p2(p2), .q2(q2),
    .v_out(f_v), .d1(f_d1), .d2(f_d2), .r(f_r),
    .a(f_a), .b(f_b), .c(f_c), .e(f_e), .f(f_f),
    .denom(f_den), .snum(f_num)
  );

  assign side1_in = '{d1: f_d1, d2: f_d2, r: f_r,
                      a: f_a, b: f_b, c: f_c, e: f_e, f: f_f};

  ssd_div #(.NW(BGW), .QB(PW), .side_t(side1_t)) u_div_s (
    .clk(clk), .rst(rst), .en(en), .v_in(f_v),
    .num(f_num), .den(f_den), .side_in(side1_in),
    .v_out(q1_v), .q(s_q), .side_out(side1_out)
  );

  ssd_mid #(.W(W)) u_mid (
    .clk(clk), .rst(rst), .en(en), .v_in(q1_v), .s(s_q),
    .a($signed(side1_out.a)), .b($signed(side1_out.b)),
    .c($signed(side1_out.c)), .e($signed(side1_out.e)),
    .f($signed(side1_out.f)),
    .d1_in(side1_out.d1), .d2_in(side1_out.d2), .r_in(side1_out.r),
    .v_out(m_v), .dnum(m_num), .dden(m_den), .mode(m_mode),
    .s_old(m_s), .t_fix(m_t), .d1(m_d1), .d2(m_d2), .r(m_r)
  );

  assign side2_in = '{d1: m_d1, d2: m_d2, r: m_r,
                      s_old: m_s, t_fix: m_t, mode: m_mode};

  ssd_div #(.NW(TW), .QB(PW), .side_t(side2_t)) u_div_t (
    .clk(clk), .rst(rst), .en(en), .v_in(m_v),
    .num(m_num), .den(m_den), .side_in(side2_in),
    .v_out(q2_v), .q(q2_val), .side_out(side2_out)
  );

  always_comb begin
    if (side2_out.mode == SEL_T) begin
      s_fin = side2_out.s_old;
      t_fin = q2_val;
    end else begin
      s_fin = q2_val;
      t_fin = side2_out.t_fix;
    end
  end

  ssd_back #(.W(W)) u_back (
    .clk(clk), .rst(rst), .en(en), .v_in(q2_v),
    .s(s_fin), .t(t_fin),
    .d1(side2_out.d1), .d2(side2_out.d2), .r(side2_out.r),
    .v_out(b_v), .sq(b_sq)
  );

  ssd_sqrt #(.XW(SW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .v_in(b_v), .x(b_sq),
    .v_out(r_v), .root(root)
  );

  assign root_x = XW'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (en) begin
      dist_valid <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance <= (root_x > XW'(DIST_MAX)) ? DIST_MAX : root_x[DIST_W-1:0];
    end
  end

endmodule

// File: design/ssd_chk.sv
// ssd_chk: port-level checks for segment_segment_distance_top, and its bind.
// Depends on ssd_pkg.
module ssd_chk import ssd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              seg_stall,
  input logic              dist_valid,
  input logic              dist_stall,
  input logic [DIST_W-1:0] distance
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !dist_valid)
    else $error("output valid after reset");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_stall |=> dist_valid && $stable(distance))
    else $error("stalled result changed");

  a_stall_only_when_full: assert property (@(posedge clk)
    seg_stall |-> dist_valid && dist_stall)
    else $error("input stalled while output free");

  a_stall_propagates: assert property (@(posedge clk)
    dist_valid && dist_stall |-> seg_stall)
    else $error("input taken while pipeline frozen");

endmodule

bind segment_segment_distance_top ssd_chk u_chk (
  .clk(clk), .rst(rst), .seg_stall(seg_stall),
  .dist_valid(dist_valid), .dist_stall(dist_stall), .distance(distance)
);
